/* sv/cbiq_pkg.sv */
// Shared types, constants and coefficient table for the cascaded biquad filter.
`default_nettype none

package cbiq_pkg;

  localparam int TABLE_SECTIONS = 5;
  localparam int SAMPLE_W       = 16;
  localparam int ACC_W          = 32;
  localparam int COEF_W         = 18;
  localparam int PROD_W         = COEF_W + ACC_W;
  localparam int FRAC_BITS      = 15;
  localparam int TSEC_W         = $clog2(TABLE_SECTIONS);
  localparam int STEP_W         = 3;

  typedef enum logic [2:0] {
    C_B0,
    C_B1,
    C_B2,
    C_A1,
    C_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPND_D0,
    OPND_D1,
    OPND_W
  } opnd_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_W_FIRST,
    ACC_W_SUB,
    ACC_Y_LOAD,
    ACC_Y_ADD
  } acc_op_t;

  typedef struct packed {
    logic      load_sample;
    coef_sel_t coef;
    opnd_sel_t opnd;
    acc_op_t   acc;
    logic      wr_delay;
    logic      load_out;
  } cbiq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } cbiq_stat_t;

  function automatic logic signed [COEF_W-1:0] coef_lookup(
    input logic [TSEC_W-1:0] sec,
    input coef_sel_t         sel
  );
    logic signed [COEF_W-1:0] c;
    c = '0;
    unique case (sec)
      3'd0: begin
        case (sel)
          C_B0:    c = 18'sd10;
          C_B1:    c = 18'sd21;
          C_B2:    c = 18'sd11;
          C_A1:    c = -18'sd13113;
          C_A2:    c = 18'sd1499;
          default: c = '0;
        endcase
      end
      3'd1: begin
        case (sel)
          C_B0:    c = 18'sd32768;
          C_B1:    c = 18'sd67707;
          C_B2:    c = 18'sd35049;
          C_A1:    c = -18'sd13756;
          C_A2:    c = 18'sd3178;
          default: c = '0;
        endcase
      end
      3'd2: begin
        case (sel)
          C_B0:    c = 18'sd32768;
          C_B1:    c = 18'sd65452;
          C_B2:    c = 18'sd32790;
          C_A1:    c = -18'sd15170;
          C_A2:    c = 18'sd6872;
          default: c = '0;
        endcase
      end
      3'd3: begin
        case (sel)
          C_B0:    c = 18'sd32768;
          C_B1:    c = 18'sd63313;
          C_B2:    c = 18'sd30649;
          C_A1:    c = -18'sd17669;
          C_A2:    c = 18'sd13403;
          default: c = '0;
        endcase
      end
      3'd4: begin
        case (sel)
          C_B0:    c = 18'sd32768;
          C_B1:    c = 18'sd62047;
          C_B2:    c = 18'sd29381;
          C_A1:    c = -18'sd21913;
          C_A2:    c = 18'sd24492;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/cbiq_if.sv */
// Request channel interfaces for input and filtered samples.
`default_nettype none

interface cbiq_in_if
  import cbiq_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cbiq_out_if
  import cbiq_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* sv/cbiq_dp.sv */
// Datapath: delay words, shared multiplier, accumulators and output register.
`default_nettype none

module cbiq_dp
  import cbiq_pkg::*;
#(
  parameter int SECTIONS = 5,
  parameter int SEC_W    = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cbiq_cmd_t                  cmd,
  input  wire logic [SEC_W-1:0]           sec,
  output cbiq_stat_t                      stat,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      sample_out
);

  logic signed [SAMPLE_W-1:0] d0_r [SECTIONS];
  logic signed [SAMPLE_W-1:0] d1_r [SECTIONS];
  logic signed [ACC_W-1:0]    w_r;
  logic signed [ACC_W-1:0]    y_r;
  logic signed [ACC_W-1:0]    mulq_r;
  acc_op_t                    acc_r;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic                       out_valid_r;

  logic signed [COEF_W-1:0]   coef;
  logic signed [ACC_W-1:0]    opnd;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    mulq_nxt;

  always_comb begin
    coef = coef_lookup(TSEC_W'(sec), cmd.coef);
    case (cmd.opnd)
      OPND_D0: opnd = ACC_W'(d0_r[sec]);
      OPND_D1: opnd = ACC_W'(d1_r[sec]);
      OPND_W:  opnd = w_r;
      default: opnd = '0;
    endcase
    prod     = PROD_W'(coef) * PROD_W'(opnd);
    mulq_nxt = prod[FRAC_BITS+ACC_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    mulq_r <= mulq_nxt;
    if (cmd.load_sample) begin
      y_r <= ACC_W'(sample_in);
    end else begin
      case (acc_r)
        ACC_W_FIRST: w_r <= y_r - mulq_r;
        ACC_W_SUB:   w_r <= w_r - mulq_r;
        ACC_Y_LOAD:  y_r <= mulq_r;
        ACC_Y_ADD:   y_r <= y_r + mulq_r;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_data_r <= y_r[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= ACC_NONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        d0_r[i] <= '0;
        d1_r[i] <= '0;
      end
    end else begin
      acc_r <= cmd.acc;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.wr_delay) begin
        d1_r[sec] <= d0_r[sec];
        d0_r[sec] <= w_r[SAMPLE_W-1:0];
      end
    end
  end

  assign stat.out_busy = out_valid_r & ~out_ready;
  assign out_valid     = out_valid_r;
  assign sample_out    = out_data_r;

endmodule

`default_nettype wire

/* sv/cbiq_ctrl.sv */
// Controller: sequences five multiplies per section over the cascade.
`default_nettype none

module cbiq_ctrl
  import cbiq_pkg::*;
#(
  parameter int SECTIONS = 5,
  parameter int SEC_W    = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cbiq_stat_t       stat,
  output cbiq_cmd_t             cmd,
  output logic [SEC_W-1:0]      sec
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_FIN
  } state_t;

  localparam logic [SEC_W-1:0]  LAST_SEC  = SEC_W'(SECTIONS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(4);

  state_t            state_r;
  logic [SEC_W-1:0]  sec_r;
  logic [STEP_W-1:0] step_r;

  always_comb begin
    cmd             = '0;
    cmd.coef        = C_B0;
    cmd.opnd        = OPND_D0;
    cmd.acc         = ACC_NONE;
    cmd.load_sample = in_valid && (state_r == S_IDLE);
    if (state_r == S_RUN) begin
      case (step_r)
        3'd0: begin
          cmd.coef = C_A1;
          cmd.opnd = OPND_D0;
          cmd.acc  = ACC_W_FIRST;
        end
        3'd1: begin
          cmd.coef = C_A2;
          cmd.opnd = OPND_D1;
          cmd.acc  = ACC_W_SUB;
        end
        3'd2: begin
          cmd.coef = C_B1;
          cmd.opnd = OPND_D0;
          cmd.acc  = ACC_Y_LOAD;
        end
        3'd3: begin
          cmd.coef = C_B2;
          cmd.opnd = OPND_D1;
          cmd.acc  = ACC_Y_ADD;
        end
        default: begin
          cmd.coef     = C_B0;
          cmd.opnd     = OPND_W;
          cmd.acc      = ACC_Y_ADD;
          cmd.wr_delay = 1'b1;
        end
      endcase
    end
    cmd.load_out = (state_r == S_FIN) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sec_r   <= '0;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            sec_r   <= '0;
            step_r  <= '0;
          end
        end
        S_RUN: begin
          if (step_r == LAST_STEP) begin
            step_r <= '0;
            if (sec_r == LAST_SEC) begin
              state_r <= S_FLUSH;
            end else begin
              sec_r <= sec_r + 1'b1;
            end
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_FLUSH: state_r <= S_FIN;
        S_FIN: begin
          if (!stat.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign sec      = sec_r;

endmodule

`default_nettype wire

/* sv/cascaded_biquad_iir_q15_unit.sv */
// Top level: cascade of Q15 Direct Form II biquad sections on one shared multiplier.
// The cascade has S = min(NUM_SECTIONS, 5) sections on the single 18x32 multiplier, doing
// five products per section; a new request is taken only once the previous sample has
// been loaded into the output register.
// A finished sample waits in the output register; a new request is taken meanwhile.
// Reset clears the delay words, the controller and the output valid flag, not the output data.
`default_nettype none

module cascaded_biquad_iir_q15_unit
  import cbiq_pkg::*;
#(
  parameter int NUM_SECTIONS = 5
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbiq_in_if.sink     in_bus,
  cbiq_out_if.source  out_bus
);

  localparam int SECTIONS = (NUM_SECTIONS < TABLE_SECTIONS) ? NUM_SECTIONS : TABLE_SECTIONS;
  localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  cbiq_cmd_t        cmd;
  cbiq_stat_t       stat;
  logic [SEC_W-1:0] sec;

  cbiq_ctrl #(
    .SECTIONS (SECTIONS),
    .SEC_W    (SEC_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd),
    .sec      (sec)
  );

  cbiq_dp #(
    .SECTIONS (SECTIONS),
    .SEC_W    (SEC_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sec        (sec),
    .stat       (stat),
    .sample_in  (in_bus.sample_in),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .sample_out (out_bus.sample_out)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("request accepted while previous sample still in work");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.out_busy)
    else $error("output register overwritten before taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(cmd.load_out))
    else $error("output valid without a finished sample");

endmodule

`default_nettype wire
